// ===== hdl/pwc_pkg.sv =====
// Shared types, constants and helper functions for the privileged
// instruction whitelist checker. Used by every module in hdl/.
// No dependencies.
package pwc_pkg;

   // Table geometry
   localparam int TABLE_SIZE = 1024;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);

   // Fixed field widths
   localparam int WORD_W = 32;
   localparam int SLOT_W = 11;
   localparam int LEN_W  = 6;

   // Privileged encoding: bits 31..22 hold this pattern and bit 20 or 19 is set
   localparam logic [9:0] PRIV_PATTERN = 10'd852;

   // Reset value of the compare length register
   localparam logic [LEN_W-1:0] LEN_RESET = 6'd27;

   // Word operations
   typedef enum logic {
      OP_SCAN   = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   // Check outcome
   typedef enum logic [1:0] {
      VERDICT_NONE = 2'd0,
      VERDICT_GOOD = 2'd1,
      VERDICT_BAD  = 2'd2
   } verdict_type;

   // One word in flight
   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [WORD_W-1:0] word;
      logic              seg;
      logic [SLOT_W-1:0] slot;
   } item_type;

   // Hash: (bits 21..12 xor bits 11..5) plus 1
   function automatic logic [SLOT_W-1:0] slot_of(input logic [WORD_W-1:0] word);
      logic [9:0] mix;
      mix = word[21:12] ^ {3'b000, word[11:5]};
      return {1'b0, mix} + 11'd1;
   endfunction

   function automatic logic in_range(input logic [SLOT_W-1:0] slot);
      return slot < SLOT_W'(TABLE_SIZE);
   endfunction

   function automatic logic is_privileged(input logic [WORD_W-1:0] word);
      return (word[31:22] == PRIV_PATTERN) && (word[20] || word[19]);
   endfunction

   // Mask of the top len bits; len of 32 or more selects the whole word
   function automatic logic [WORD_W-1:0] top_mask(input logic [LEN_W-1:0] len);
      logic [WORD_W-1:0] m;
      if (len >= 6'd32) begin
         m = '1;
      end else begin
         m = ~({WORD_W{1'b1}} >> len);
      end
      return m;
   endfunction

   // A scan that needs a table lookup
   function automatic logic needs_check(input item_type item);
      return item.valid && (item.op == OP_SCAN) && is_privileged(item.word)
             && in_range(item.slot);
   endfunction

   // An insert that lands inside the table
   function automatic logic needs_write(input item_type item);
      return item.valid && (item.op == OP_INSERT) && in_range(item.slot);
   endfunction

endpackage

// ===== hdl/pwc_front.sv =====
// Input register stage: captures the accepted word and hashes its slot.
// Depends on pwc_pkg.
module pwc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  pwc_pkg::op_type           operation,
   input  logic [pwc_pkg::WORD_W-1:0] instruction_word,
   input  logic                      segment_end,
   output pwc_pkg::item_type         item
);

   logic                       valid_ff;
   pwc_pkg::op_type            op_ff;
   logic [pwc_pkg::WORD_W-1:0] word_ff;
   logic                       seg_ff;

   // Valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   // Payload, loaded on accept only
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= operation;
         word_ff <= instruction_word;
         seg_ff  <= segment_end;
      end
   end

   // Slot hash is a short xor and increment
   always_comb begin
      item.valid = valid_ff;
      item.op    = op_ff;
      item.word  = word_ff;
      item.seg   = seg_ff;
      item.slot  = pwc_pkg::slot_of(word_ff);
   end

endmodule

// ===== hdl/pwc_table.sv =====
// Whitelist table: one-write one-read memory with a clearing sweep after reset.
// Depends on pwc_pkg.
module pwc_table (
   input  logic                       clock,
   input  logic                       reset,
   input  pwc_pkg::item_type          item,
   output logic [pwc_pkg::WORD_W-1:0] rd_data,
   output logic                       clearing
);

   logic [pwc_pkg::WORD_W-1:0] mem [pwc_pkg::TABLE_SIZE];
   logic [pwc_pkg::WORD_W-1:0] rd_data_ff;
   logic                       clear_ff;
   logic                       clear_in;
   logic [pwc_pkg::ADDR_W-1:0] clr_addr_ff;
   logic [pwc_pkg::ADDR_W-1:0] clr_addr_in;
   logic [pwc_pkg::ADDR_W-1:0] addr;
   logic                       last_clr;

   assign addr     = item.slot[pwc_pkg::ADDR_W-1:0];
   assign last_clr = clr_addr_ff == pwc_pkg::ADDR_W'(pwc_pkg::TABLE_SIZE - 1);

   // Sweep control: one entry zeroed per cycle
   always_comb begin
      clear_in    = clear_ff && !last_clr;
      clr_addr_in = clear_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Write port: sweep or insert
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (pwc_pkg::needs_write(item)) begin
         mem[addr] <= item.word;
      end
   end

   // Registered read for scans
   always_ff @(posedge clock) begin
      if (pwc_pkg::needs_check(item)) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_ff;

endmodule

// ===== hdl/pwc_verdict.sv =====
// Compare stage and result register: masks stored and scanned words and
// forms the verdict. Depends on pwc_pkg.
module pwc_verdict (
   input  logic                       clock,
   input  logic                       reset,
   input  pwc_pkg::item_type          item,
   input  logic [pwc_pkg::WORD_W-1:0] rd_data,
   input  logic [pwc_pkg::LEN_W-1:0]  compare_length,
   output logic                       strobe,
   output pwc_pkg::verdict_type       verdict,
   output logic [pwc_pkg::SLOT_W-1:0] slot_index,
   output logic                       segment_done
);

   pwc_pkg::item_type          s2_ff;
   logic                       s2_check_ff;
   logic                       strobe_ff;
   pwc_pkg::verdict_type       verdict_ff;
   pwc_pkg::verdict_type       verdict_in;
   logic [pwc_pkg::SLOT_W-1:0] slot_ff;
   logic                       seg_ff;
   logic [pwc_pkg::WORD_W-1:0] mask;

   // Item travels alongside the table read
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else begin
         s2_ff.valid <= item.valid;
      end
      s2_ff.op    <= item.op;
      s2_ff.word  <= item.word;
      s2_ff.seg   <= item.seg;
      s2_ff.slot  <= item.slot;
      s2_check_ff <= pwc_pkg::needs_check(item);
   end

   // Masked compare; an all-zero entry is empty
   always_comb begin
      mask       = pwc_pkg::top_mask(compare_length);
      verdict_in = pwc_pkg::VERDICT_NONE;
      if (s2_check_ff) begin
         if ((rd_data != '0) && ((rd_data & mask) == (s2_ff.word & mask))) begin
            verdict_in = pwc_pkg::VERDICT_GOOD;
         end else begin
            verdict_in = pwc_pkg::VERDICT_BAD;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
      slot_ff    <= s2_ff.slot;
      seg_ff     <= s2_ff.seg;
   end

   assign strobe       = strobe_ff;
   assign verdict      = verdict_ff;
   assign slot_index   = slot_ff;
   assign segment_done = seg_ff;

endmodule

// ===== hdl/privileged_instruction_whitelist_check.sv =====
// Top level of the privileged instruction whitelist checker.
// Depends on pwc_pkg, pwc_front, pwc_table and pwc_verdict.
//
//   channel   handshake          payload
//   -------   ----------------   ----------------------------------------------
//   request   start / busy       req_operation, req_instruction_word,
//                                req_segment_end
//   response  rsp_strobe         rsp_verdict, rsp_slot_index, rsp_segment_done
//   control   csr_wr_en          csr_wr_data (compare length)
//
// A word is taken every cycle while busy is low; it passes the input register,
// the table read register and the result register, and its result is taken
// while its strobe is high.
// After reset, busy stays high while the table is swept to zero, one entry
// per cycle.
// Results are shown for one cycle and cannot be held off by the receiver.
module privileged_instruction_whitelist_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_instruction_word,
   input  logic        req_segment_end,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_verdict,
   output logic [10:0] rsp_slot_index,
   output logic        rsp_segment_done,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   pwc_pkg::item_type          s1_item;
   pwc_pkg::verdict_type       verdict;
   logic [pwc_pkg::WORD_W-1:0] rd_data;
   logic [pwc_pkg::LEN_W-1:0]  cmp_len_ff;
   logic                       clearing;
   logic                       accept;

   assign busy   = clearing || reset;
   assign accept = start && !busy;

   // Compare length register
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_len_ff <= pwc_pkg::LEN_RESET;
      end else if (csr_wr_en) begin
         cmp_len_ff <= csr_wr_data;
      end
   end

   pwc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .operation        (pwc_pkg::op_type'(req_operation)),
      .instruction_word (req_instruction_word),
      .segment_end      (req_segment_end),
      .item             (s1_item)
   );

   pwc_table u_table (
      .clock    (clock),
      .reset    (reset),
      .item     (s1_item),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

   pwc_verdict u_verdict (
      .clock          (clock),
      .reset          (reset),
      .item           (s1_item),
      .rd_data        (rd_data),
      .compare_length (cmp_len_ff),
      .strobe         (rsp_strobe),
      .verdict        (verdict),
      .slot_index     (rsp_slot_index),
      .segment_done   (rsp_segment_done)
   );

   assign rsp_verdict = verdict;

endmodule
